/* hw/rtl/grid_rectangle_placer_macros.svh */
// Assertion shorthands for the grid rectangle placer checks.
`ifndef GRID_RECTANGLE_PLACER_MACROS_SVH
`define GRID_RECTANGLE_PLACER_MACROS_SVH

// Same-cycle implication, held off during reset
`define GRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid placer check failed");

// Next-cycle implication, held off during reset
`define GRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid placer check failed");

`endif

/* hw/rtl/grp_pkg.sv */
package grp_pkg;

    localparam int GRID_X_DEF = 16;
    localparam int GRID_Y_DEF = 16;
    localparam int COORD_W    = 8;
    localparam int SIZE_W     = 5;
    localparam int RUN_W      = 5;
    localparam int CFG_W      = 16;
    localparam int CIDX_W     = 3;
    localparam int PX_W       = 17;
    localparam int STEP_W     = 13;
    localparam int PT_W       = 17;
    localparam int BOUND_W    = 17;

    typedef logic [COORD_W-1:0] t_coord;

    // Request codes
    localparam logic [2:0] REQ_FIRST = 3'd0;
    localparam logic [2:0] REQ_NEAR  = 3'd1;
    localparam logic [2:0] REQ_FREE  = 3'd2;
    localparam logic [2:0] REQ_FITS  = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    // Status codes
    localparam logic [2:0] ST_PLACED = 3'd0;
    localparam logic [2:0] ST_NOROOM = 3'd1;
    localparam logic [2:0] ST_FREED  = 3'd2;
    localparam logic [2:0] ST_FIT    = 3'd3;
    localparam logic [2:0] ST_CELL   = 3'd4;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_BORDER = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_CELL_W = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_CELL_H = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_GAP_X  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_GAP_Y  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_CONT_W = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_CONT_H = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_UPD,
        S_SCAN_CHK,
        S_SCAN_X,
        S_SCAN_END,
        S_PICK,
        S_MARK_RD,
        S_MARK_WR,
        S_CELL_RD,
        S_CELL_ANS,
        S_DONE
    } t_state;

    typedef struct packed {
        logic   clear;
        logic   row;
        logic   step;
        logic   cand;
        t_coord x;
        t_coord y;
    } t_dist_ctl;

    typedef struct packed {
        logic   found;
        t_coord x;
        t_coord y;
    } t_dist_res;

    // Pixel extent of n cells with gaps between them, saturated
    function automatic logic [PX_W-1:0] px_size(input logic [11:0] unit_px,
                                                input logic [11:0] gap,
                                                input logic [SIZE_W-1:0] n);
        logic [17:0]       v;
        logic [SIZE_W-1:0] nm1;
        logic [PX_W-1:0]   res;
        nm1 = n - 1'b1;
        v   = ({6'd0, unit_px} * {13'd0, n}) + ({6'd0, gap} * {13'd0, nm1});
        if (n == '0) begin
            res = '0;
        end else if (v > 18'd131071) begin
            res = '1;
        end else begin
            res = v[PX_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/grp_ram.sv */
module grp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hw/rtl/grp_fit.sv */
module grp_fit #(
    parameter int GRID_X = grp_pkg::GRID_X_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_load,
    input  logic [GRID_X-1:0]          i_row,
    input  logic [grp_pkg::SIZE_W-1:0] i_sx,
    input  logic [grp_pkg::SIZE_W-1:0] i_sy,
    output logic [GRID_X-1:0]          o_fit
);

    localparam int RUN_W = grp_pkg::RUN_W;

    logic [RUN_W-1:0]  r_run [GRID_X];
    logic [RUN_W-1:0]  n_run [GRID_X];
    logic [GRID_X-1:0] tall;
    logic [GRID_X-1:0] fit;

    // Count free rows ending at the current row, per column
    always_comb begin
        for (int c = 0; c < GRID_X; c++) begin
            if (i_row[c]) begin
                n_run[c] = '0;
            end else if (r_run[c] == '1) begin
                n_run[c] = r_run[c];
            end else begin
                n_run[c] = r_run[c] + 1'b1;
            end
            tall[c] = (n_run[c] >= i_sy);
        end
    end

    // An origin fits when every column of its window is tall enough
    always_comb begin
        for (int x = 0; x < GRID_X; x++) begin
            fit[x] = ((x + int'(i_sx)) <= GRID_X);
            for (int c = 0; c < GRID_X; c++) begin
                if ((c >= x) && (c < x + int'(i_sx)) && !tall[c]) begin
                    fit[x] = 1'b0;
                end
            end
        end
    end

    // Hold run lengths across rows
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < GRID_X; c++) begin
            if (!i_rst_n || i_clear) begin
                r_run[c] <= '0;
            end else if (i_load) begin
                r_run[c] <= n_run[c];
            end
        end
    end

    // Register the fit vector of the row just taken
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_fit <= fit;
        end
    end

endmodule

/* hw/rtl/grp_dist.sv */
module grp_dist #(
    parameter int GRID_X = grp_pkg::GRID_X_DEF,
    parameter int GRID_Y = grp_pkg::GRID_Y_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  grp_pkg::t_dist_ctl                 i_ctl,
    input  logic signed [grp_pkg::PT_W-1:0]    i_pxb,
    input  logic signed [grp_pkg::PT_W-1:0]    i_pyb,
    input  logic [grp_pkg::STEP_W-1:0]         i_stepx,
    input  logic [grp_pkg::STEP_W-1:0]         i_stepy,
    input  logic [grp_pkg::BOUND_W-1:0]        i_bound,
    output grp_pkg::t_dist_res                 o_res
);

    localparam int MX    = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
    localparam int OFS_W = grp_pkg::STEP_W + $clog2(MX);
    localparam int DIF_W = ((OFS_W > grp_pkg::PT_W) ? OFS_W : grp_pkg::PT_W) + 2;
    localparam int D_W   = DIF_W + 1;

    logic [OFS_W-1:0]        r_ox;
    logic [OFS_W-1:0]        r_oy;
    logic [DIF_W-1:0]        r_dya;
    logic [D_W-1:0]          r_d;
    logic [D_W-1:0]          r_best;
    logic                    r_dv;
    logic                    r_found;
    grp_pkg::t_coord         r_dx;
    grp_pkg::t_coord         r_dy;
    grp_pkg::t_coord         r_bx;
    grp_pkg::t_coord         r_by;

    logic signed [DIF_W-1:0] ax;
    logic signed [DIF_W-1:0] bx;
    logic signed [DIF_W-1:0] dx;
    logic signed [DIF_W-1:0] ay;
    logic signed [DIF_W-1:0] by;
    logic signed [DIF_W-1:0] dy;
    logic [DIF_W-1:0]        absx;
    logic [DIF_W-1:0]        absy;
    logic                    better;

    // Offsets from the target point to the current cell origin
    always_comb begin
        ax   = DIF_W'(i_pxb);
        bx   = DIF_W'(r_ox);
        dx   = ax - bx;
        absx = (dx < 0) ? DIF_W'(-dx) : DIF_W'(dx);
        ay   = DIF_W'(i_pyb);
        by   = DIF_W'(r_oy);
        dy   = ay - by;
        absy = (dy < 0) ? DIF_W'(-dy) : DIF_W'(dy);
    end

    // Strictly closer wins; a tie goes to the lower column
    assign better = (r_d < r_best) || (r_found && (r_d == r_best) && (r_dx < r_bx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv    <= 1'b0;
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_dv    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_dv <= i_ctl.step && i_ctl.cand;
            if (r_dv && better) begin
                r_found <= 1'b1;
            end
        end
    end

    // Advance origin offsets, compute distance, track the best origin
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_oy   <= '0;
            r_ox   <= '0;
            r_best <= D_W'(i_bound);
        end else begin
            if (i_ctl.row) begin
                r_dya <= absy;
                r_oy  <= r_oy + OFS_W'(i_stepy);
                r_ox  <= '0;
            end else if (i_ctl.step) begin
                r_ox <= r_ox + OFS_W'(i_stepx);
            end
            if (r_dv && better) begin
                r_best <= r_d;
                r_bx   <= r_dx;
                r_by   <= r_dy;
            end
        end
        r_d  <= D_W'(absx) + D_W'(r_dya);
        r_dx <= i_ctl.x;
        r_dy <= i_ctl.y;
    end

    assign o_res.found = r_found;
    assign o_res.x     = r_bx;
    assign o_res.y     = r_by;

endmodule

/* hw/rtl/grid_rectangle_placer.sv */
// Channel   Direction  Handshake              Payload
// config    in         i_cfg_we               i_cfg_idx, i_cfg_data
// request   in         start high, busy low   i_req_type .. i_point_y
// result    out        o_done (one cycle)     o_status .. o_height_px
//
// One request at a time; busy stays high from accept through the o_done cycle.
// Place first fit and fits anywhere: grid rows are read, updated and checked in
// turn until a fit; place first fit then reads and writes each marked row.
// Place nearest: the scan is set by the single distance unit stepping one column
// per cycle, then the rows are marked. Free: each row is read and written back.
// Read cell: a row read, then the answer. Reset is synchronous; the occupancy
// rows read as free after reset by their valid bits. Results cannot be stalled.
module grid_rectangle_placer #(
    parameter int GRID_X = grp_pkg::GRID_X_DEF,
    parameter int GRID_Y = grp_pkg::GRID_Y_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [grp_pkg::CIDX_W-1:0]        i_cfg_idx,
    input  logic [grp_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        i_req_type,
    input  logic [4:0]                        i_size_x,
    input  logic [4:0]                        i_size_y,
    input  logic [3:0]                        i_cell_x,
    input  logic [3:0]                        i_cell_y,
    input  logic signed [15:0]                i_point_x,
    input  logic signed [15:0]                i_point_y,
    output logic                              o_done,
    output logic [2:0]                        o_status,
    output logic                              o_found,
    output logic [3:0]                        o_placed_x,
    output logic [3:0]                        o_placed_y,
    output logic [16:0]                       o_width_px,
    output logic [16:0]                       o_height_px
);

    localparam int CW = grp_pkg::COORD_W;
    localparam int AW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int XW = (GRID_X > 1) ? $clog2(GRID_X) : 1;

    grp_pkg::t_state r_state;
    grp_pkg::t_state n_state;

    // Configuration
    logic [11:0] r_border;
    logic [11:0] r_cell_w;
    logic [11:0] r_cell_h;
    logic [11:0] r_gap_x;
    logic [11:0] r_gap_y;
    logic [15:0] r_cont_w;
    logic [15:0] r_cont_h;

    // Request
    logic [2:0]                      r_req;
    logic [4:0]                      r_sx;
    logic [4:0]                      r_sy;
    grp_pkg::t_coord                 r_cx;
    grp_pkg::t_coord                 r_cy;
    logic signed [grp_pkg::PT_W-1:0] r_pxb;
    logic signed [grp_pkg::PT_W-1:0] r_pyb;

    // Scan and mark
    grp_pkg::t_coord r_yend;
    grp_pkg::t_coord r_orgy;
    grp_pkg::t_coord r_xi;
    grp_pkg::t_coord r_mx;
    grp_pkg::t_coord r_my;
    grp_pkg::t_coord r_mr;
    logic            r_mset;

    // Result
    logic [2:0]      r_status;
    logic            r_found;
    grp_pkg::t_coord r_rx;
    grp_pkg::t_coord r_ry;
    logic [16:0]     r_wpx;
    logic [16:0]     r_hpx;

    // Occupancy store
    logic [GRID_Y-1:0] r_row_vld;
    logic              r_rd_vld;
    logic [AW-1:0]     ram_raddr;
    logic [AW-1:0]     ram_waddr;
    logic              ram_we;
    logic [GRID_X-1:0] ram_wdata;
    logic [GRID_X-1:0] ram_rdata;
    logic [GRID_X-1:0] row_q;

    logic                accept;
    logic                org_valid;
    grp_pkg::t_coord     org_y;
    logic                last_row;
    logic                last_x;
    logic [GRID_X-1:0]   fit;
    logic                fit_any;
    grp_pkg::t_coord     sel_x;
    grp_pkg::t_coord     mrow;
    logic                mark_end;
    logic [GRID_X-1:0]   mask;
    logic                cell_bit;
    logic                fit_clear;
    logic                fit_load;
    grp_pkg::t_dist_ctl  dctl;
    grp_pkg::t_dist_res  dres;

    assign accept = start && !busy;
    assign row_q  = r_rd_vld ? ram_rdata : '0;

    // Origin row that the row just read completes
    assign org_valid = (r_sy == '0) || ((r_yend + 1'b1) >= CW'(r_sy));
    assign org_y     = (r_sy == '0) ? r_yend : (r_yend + 1'b1 - CW'(r_sy));
    assign last_row  = (r_yend == CW'(GRID_Y - 1));
    assign last_x    = (r_xi == CW'(GRID_X - 1));
    assign fit_any   = |fit;
    assign mrow      = r_my + r_mr;
    assign mark_end  = (r_mr >= CW'(r_sy)) || (mrow >= CW'(GRID_Y));

    // Lowest fitting column
    always_comb begin
        sel_x = '0;
        for (int x = GRID_X - 1; x >= 0; x--) begin
            if (fit[x]) begin
                sel_x = CW'(x);
            end
        end
    end

    // Column span of the rectangle being marked or cleared
    always_comb begin
        for (int c = 0; c < GRID_X; c++) begin
            mask[c] = (CW'(c) >= r_mx) && (CW'(c) < (r_mx + CW'(r_sx)));
        end
    end

    // Pick one cell out of the row read
    always_comb begin
        cell_bit = 1'b0;
        for (int c = 0; c < GRID_X; c++) begin
            if (CW'(c) == r_cx) begin
                cell_bit = row_q[c];
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            grp_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        grp_pkg::REQ_FIRST: n_state = grp_pkg::S_SCAN_RD;
                        grp_pkg::REQ_NEAR:  n_state = grp_pkg::S_SCAN_RD;
                        grp_pkg::REQ_FITS:  n_state = grp_pkg::S_SCAN_RD;
                        grp_pkg::REQ_FREE:  n_state = grp_pkg::S_MARK_RD;
                        grp_pkg::REQ_READ:  n_state = grp_pkg::S_CELL_RD;
                        default:            n_state = grp_pkg::S_DONE;
                    endcase
                end
            end
            grp_pkg::S_SCAN_RD: n_state = grp_pkg::S_SCAN_UPD;
            grp_pkg::S_SCAN_UPD: begin
                if (!org_valid) begin
                    if (!last_row) begin
                        n_state = grp_pkg::S_SCAN_RD;
                    end else if (r_req == grp_pkg::REQ_NEAR) begin
                        n_state = grp_pkg::S_SCAN_END;
                    end else begin
                        n_state = grp_pkg::S_DONE;
                    end
                end else if (r_req == grp_pkg::REQ_NEAR) begin
                    n_state = grp_pkg::S_SCAN_X;
                end else begin
                    n_state = grp_pkg::S_SCAN_CHK;
                end
            end
            grp_pkg::S_SCAN_CHK: begin
                if (fit_any) begin
                    n_state = (r_req == grp_pkg::REQ_FIRST) ? grp_pkg::S_MARK_RD
                                                            : grp_pkg::S_DONE;
                end else begin
                    n_state = last_row ? grp_pkg::S_DONE : grp_pkg::S_SCAN_RD;
                end
            end
            grp_pkg::S_SCAN_X: begin
                if (last_x) begin
                    n_state = last_row ? grp_pkg::S_SCAN_END : grp_pkg::S_SCAN_RD;
                end
            end
            grp_pkg::S_SCAN_END: n_state = grp_pkg::S_PICK;
            grp_pkg::S_PICK: begin
                n_state = dres.found ? grp_pkg::S_MARK_RD : grp_pkg::S_DONE;
            end
            grp_pkg::S_MARK_RD: begin
                n_state = mark_end ? grp_pkg::S_DONE : grp_pkg::S_MARK_WR;
            end
            grp_pkg::S_MARK_WR:  n_state = grp_pkg::S_MARK_RD;
            grp_pkg::S_CELL_RD:  n_state = grp_pkg::S_CELL_ANS;
            grp_pkg::S_CELL_ANS: n_state = grp_pkg::S_DONE;
            grp_pkg::S_DONE:     n_state = grp_pkg::S_IDLE;
            default:             n_state = grp_pkg::S_IDLE;
        endcase
    end

    // Datapath controls per state
    always_comb begin
        ram_raddr = '0;
        ram_waddr = mrow[AW-1:0];
        ram_we    = 1'b0;
        ram_wdata = r_mset ? (row_q | mask) : (row_q & ~mask);
        fit_clear = accept;
        fit_load  = 1'b0;
        dctl.clear = accept;
        dctl.row   = 1'b0;
        dctl.step  = 1'b0;
        dctl.cand  = fit[r_xi[XW-1:0]];
        dctl.x     = r_xi;
        dctl.y     = r_orgy;
        case (r_state)
            grp_pkg::S_SCAN_RD: ram_raddr = r_yend[AW-1:0];
            grp_pkg::S_SCAN_UPD: begin
                fit_load = 1'b1;
                dctl.row = org_valid && (r_req == grp_pkg::REQ_NEAR);
            end
            grp_pkg::S_SCAN_X:  dctl.step = 1'b1;
            grp_pkg::S_MARK_RD: ram_raddr = mrow[AW-1:0];
            grp_pkg::S_MARK_WR: ram_we    = 1'b1;
            grp_pkg::S_CELL_RD: ram_raddr = r_cy[AW-1:0];
            default: ;
        endcase
    end

    assign busy   = (r_state != grp_pkg::S_IDLE);
    assign o_done = (r_state == grp_pkg::S_DONE);

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= grp_pkg::S_IDLE;
            r_row_vld <= '0;
            r_border  <= 12'd0;
            r_cell_w  <= 12'd64;
            r_cell_h  <= 12'd64;
            r_gap_x   <= 12'd0;
            r_gap_y   <= 12'd0;
            r_cont_w  <= 16'd1920;
            r_cont_h  <= 16'd1080;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_row_vld[ram_waddr] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    grp_pkg::CFG_BORDER: r_border <= i_cfg_data[11:0];
                    grp_pkg::CFG_CELL_W: r_cell_w <= i_cfg_data[11:0];
                    grp_pkg::CFG_CELL_H: r_cell_h <= i_cfg_data[11:0];
                    grp_pkg::CFG_GAP_X:  r_gap_x  <= i_cfg_data[11:0];
                    grp_pkg::CFG_GAP_Y:  r_gap_y  <= i_cfg_data[11:0];
                    grp_pkg::CFG_CONT_W: r_cont_w <= i_cfg_data;
                    grp_pkg::CFG_CONT_H: r_cont_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Request, scan counters and result word
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_row_vld[ram_raddr];
        case (r_state)
            grp_pkg::S_IDLE: begin
                if (accept) begin
                    r_req  <= i_req_type;
                    r_sx   <= i_size_x;
                    r_sy   <= i_size_y;
                    r_cx   <= CW'(i_cell_x);
                    r_cy   <= CW'(i_cell_y);
                    r_pxb  <= {i_point_x[15], i_point_x} - {5'd0, r_border};
                    r_pyb  <= {i_point_y[15], i_point_y} - {5'd0, r_border};
                    r_yend <= '0;
                    r_xi   <= '0;
                    r_mx   <= CW'(i_cell_x);
                    r_my   <= CW'(i_cell_y);
                    r_mr   <= '0;
                    r_mset <= 1'b0;
                    r_wpx  <= grp_pkg::px_size(r_cell_w, r_gap_x, i_size_x);
                    r_hpx  <= grp_pkg::px_size(r_cell_h, r_gap_y, i_size_y);
                    r_found <= 1'b0;
                    r_rx    <= '0;
                    r_ry    <= '0;
                    case (i_req_type)
                        grp_pkg::REQ_FREE: begin
                            r_status <= grp_pkg::ST_FREED;
                            r_rx     <= CW'(i_cell_x);
                            r_ry     <= CW'(i_cell_y);
                        end
                        grp_pkg::REQ_READ: begin
                            r_status <= grp_pkg::ST_CELL;
                            r_rx     <= CW'(i_cell_x);
                            r_ry     <= CW'(i_cell_y);
                        end
                        grp_pkg::REQ_FITS: r_status <= grp_pkg::ST_FIT;
                        default:           r_status <= grp_pkg::ST_NOROOM;
                    endcase
                end
            end
            grp_pkg::S_SCAN_UPD: begin
                r_orgy <= org_y;
                r_xi   <= '0;
                if (!org_valid) begin
                    r_yend <= r_yend + 1'b1;
                end
            end
            grp_pkg::S_SCAN_CHK: begin
                if (fit_any) begin
                    r_found <= 1'b1;
                    if (r_req == grp_pkg::REQ_FIRST) begin
                        r_status <= grp_pkg::ST_PLACED;
                        r_rx     <= sel_x;
                        r_ry     <= r_orgy;
                        r_mx     <= sel_x;
                        r_my     <= r_orgy;
                        r_mr     <= '0;
                        r_mset   <= 1'b1;
                    end
                end else begin
                    r_yend <= r_yend + 1'b1;
                end
            end
            grp_pkg::S_SCAN_X: begin
                r_xi <= r_xi + 1'b1;
                if (last_x) begin
                    r_yend <= r_yend + 1'b1;
                end
            end
            grp_pkg::S_PICK: begin
                if (dres.found) begin
                    r_found  <= 1'b1;
                    r_status <= grp_pkg::ST_PLACED;
                    r_rx     <= dres.x;
                    r_ry     <= dres.y;
                    r_mx     <= dres.x;
                    r_my     <= dres.y;
                    r_mr     <= '0;
                    r_mset   <= 1'b1;
                end
            end
            grp_pkg::S_MARK_WR: r_mr <= r_mr + 1'b1;
            grp_pkg::S_CELL_ANS: r_found <= (r_cy < CW'(GRID_Y)) && cell_bit;
            default: ;
        endcase
    end

    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_placed_x  = r_rx[3:0];
    assign o_placed_y  = r_ry[3:0];
    assign o_width_px  = r_wpx;
    assign o_height_px = r_hpx;

    grp_ram #(
        .WIDTH (GRID_X),
        .DEPTH (GRID_Y)
    ) u_occ (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    grp_fit #(
        .GRID_X (GRID_X)
    ) u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (fit_clear),
        .i_load  (fit_load),
        .i_row   (row_q),
        .i_sx    (r_sx),
        .i_sy    (r_sy),
        .o_fit   (fit)
    );

    grp_dist #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dctl),
        .i_pxb   (r_pxb),
        .i_pyb   (r_pyb),
        .i_stepx ({1'b0, r_cell_w} + {1'b0, r_gap_x}),
        .i_stepy ({1'b0, r_cell_h} + {1'b0, r_gap_y}),
        .i_bound ({1'b0, r_cont_w} + {1'b0, r_cont_h}),
        .o_res   (dres)
    );

endmodule

/* hw/rtl/grp_checker.sv */
`include "grid_rectangle_placer_macros.svh"

module grp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [2:0] o_status,
    input logic       o_found
);

    logic found_ok;

    // Status codes that may carry a set found flag
    assign found_ok = (o_status == grp_pkg::ST_PLACED) || (o_status == grp_pkg::ST_FIT) ||
                      (o_status == grp_pkg::ST_CELL);

    // A word is only delivered while a request is in flight
    `GRP_ASSERT_IMP(a_done_busy, i_clk, i_rst_n, o_done, busy)

    // Accepting a request raises busy
    `GRP_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // Each request yields a single result word, then the block goes idle
    `GRP_ASSERT_NXT(a_done_once, i_clk, i_rst_n, o_done, !o_done && !busy)

    // Found is only reported for placement, fit or cell answers
    `GRP_ASSERT_IMP(a_found_status, i_clk, i_rst_n, o_done && o_found, found_ok)

endmodule

bind grid_rectangle_placer grp_checker u_grp_checker (.*);
